@@ hdl/rc5_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_pkg
// Shared types, constants and helpers of the RC5-32 block cipher.
// ----------------------------------------------------------------------------
package rc5_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned RotW     = 5;
  localparam int unsigned KeyWords = 4;
  localparam int unsigned RegW     = 64;
  localparam int unsigned AddrW    = 4;

  localparam logic [WordW-1:0] MagicP = 32'hB7E1_5163;
  localparam logic [WordW-1:0] MagicQ = 32'h9E37_79B9;
  localparam logic [RotW-1:0]  MixRot = 5'd3;

  // operation codes carried in tuser
  localparam logic [1:0] OpExpand  = 2'd0;
  localparam logic [1:0] OpEncrypt = 2'd1;
  localparam logic [1:0] OpDecrypt = 2'd2;

  // configuration register indexes (paddr bit 3)
  localparam logic RegKeyLow  = 1'b0;
  localparam logic RegKeyHigh = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MIX_A,
    ST_MIX_B,
    ST_CIPH,
    ST_HOLD
  } state_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_ENC,
    ALU_DEC,
    ALU_MIX_A,
    ALU_MIX_B
  } alu_mode_e;

  typedef struct packed {
    alu_mode_e        mode;
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [WordW-1:0] k;
  } alu_req_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] val,
                                            input logic [RotW-1:0]  amt);
    logic [2*WordW-1:0] dbl;
    dbl = {val, val} << amt;
    return dbl[2*WordW-1:WordW];
  endfunction

endpackage
`default_nettype wire

@@ hdl/rc5_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_alu
// Shared add / subtract / xor / rotate unit used by the key schedule and both
// cipher directions, one half-round or one mixing half-step per use.
// ----------------------------------------------------------------------------
module rc5_alu (
  input  rc5_pkg::alu_req_t          req_i,
  output logic [rc5_pkg::WordW-1:0]  res_o
);
  import rc5_pkg::*;

  logic [WordW-1:0] sum3;
  logic [WordW-1:0] sum2;
  logic [WordW-1:0] diff;
  logic [WordW-1:0] rot_in;
  logic [RotW-1:0]  rot_amt;
  logic [WordW-1:0] rot_out;

  assign sum2 = req_i.x + req_i.y;
  assign sum3 = req_i.k + sum2;
  assign diff = req_i.x - req_i.k;

  // one rotator: right rotation is a left rotation by the negated amount
  always_comb begin
    rot_in  = req_i.x;
    rot_amt = '0;
    unique case (req_i.mode)
      ALU_ENC: begin
        rot_in  = req_i.x ^ req_i.y;
        rot_amt = req_i.y[RotW-1:0];
      end
      ALU_DEC: begin
        rot_in  = diff;
        rot_amt = RotW'(0) - req_i.y[RotW-1:0];
      end
      ALU_MIX_A: begin
        rot_in  = sum3;
        rot_amt = MixRot;
      end
      ALU_MIX_B: begin
        rot_in  = sum3;
        rot_amt = sum2[RotW-1:0];
      end
      default: begin
        rot_in  = req_i.x;
        rot_amt = '0;
      end
    endcase
  end

  assign rot_out = rotl(rot_in, rot_amt);

  always_comb begin
    unique case (req_i.mode)
      ALU_ADD: res_o = req_i.x + req_i.k;
      ALU_SUB: res_o = diff;
      ALU_ENC: res_o = rot_out + req_i.k;
      ALU_DEC: res_o = rot_out ^ req_i.y;
      default: res_o = rot_out;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/rc5_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_ram
// Round key table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rc5_ram #(
  parameter  int Depth = 26,
  parameter  int Width = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ hdl/rc5_block_cipher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_block_cipher
// RC5-32 with a 128-bit key: key schedule, block encrypt and block decrypt
// on one shared ALU and a single round key table, under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         tuser = op, tdata = word_a, word_b
//  m_axis    out        tdata = out_a, out_b
//  apb       in/out     key_low at 0x0, key_high at 0x8, 64-bit data
//
// T = 2*(NUM_ROUNDS+1) round keys, one table read and one ALU pass per key.
// Encrypt/decrypt: one ALU pass per round key, then ST_HOLD until the output
// register is free. Expand: one fill step per table entry, then 3*T mixing
// steps of ST_MIX_A and ST_MIX_B. s_axis_tready is high only while
// idle; a finished block waits in the output register during the next word.
// Reset clears control and the keys; the round key table is undefined.
// ----------------------------------------------------------------------------
module rc5_block_cipher #(
  parameter int NUM_ROUNDS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [63:0]              s_axis_tdata,   // word_a [31:0], word_b [63:32]
  input  logic [1:0]               s_axis_tuser,   // op [1:0]
  // output stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [63:0]              m_axis_tdata,   // out_a [31:0], out_b [63:32]
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [rc5_pkg::AddrW-1:0] paddr,
  input  logic [rc5_pkg::RegW-1:0]  pwdata,
  output logic [rc5_pkg::RegW-1:0]  prdata,
  output logic                     pready
);
  import rc5_pkg::*;

  localparam int TableSize = 2 * (NUM_ROUNDS + 1);
  localparam int IdxW      = $clog2(TableSize);
  localparam int MixSteps  = 3 * TableSize;
  localparam int StepW     = $clog2(MixSteps);

  localparam logic [IdxW-1:0]  IdxLast  = IdxW'(TableSize - 1);
  localparam logic [StepW-1:0] StepLast = StepW'(MixSteps - 1);

  state_e state_q, state_d;

  logic [RegW-1:0]  key_low_q, key_high_q;
  logic [WordW-1:0] a_q, b_q;
  logic [IdxW-1:0]  idx_q;
  logic [StepW-1:0] step_q;
  logic [1:0]       w_q;
  logic [WordW-1:0] kw_q [KeyWords];
  logic             dec_q;
  logic             m_valid_q;
  logic [63:0]      m_data_q;

  logic             s_fire;
  logic             cfg_wr;
  logic [1:0]       op;
  logic             odd;
  logic             last_key;
  logic             out_free;
  logic [IdxW-1:0]  idx_next_mix;
  logic [IdxW-1:0]  idx_next_ciph;

  alu_req_t         alu_req;
  logic [WordW-1:0] alu_res;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  logic [WordW-1:0] ram_rdata;

  assign op            = s_axis_tuser;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign odd           = idx_q[0];
  assign last_key      = dec_q ? (idx_q == '0) : (idx_q == IdxLast);
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign idx_next_mix  = (idx_q == IdxLast) ? '0 : idx_q + IdxW'(1);
  assign idx_next_ciph = dec_q ? idx_q - IdxW'(1) : idx_q + IdxW'(1);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[3] == RegKeyHigh) ? key_high_q : key_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == RegKeyLow) begin
        key_low_q <= pwdata;
      end else begin
        key_high_q <= pwdata;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          unique case (op)
            OpExpand:  state_d = ST_INIT;
            OpEncrypt: state_d = ST_CIPH;
            OpDecrypt: state_d = ST_CIPH;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_INIT:  if (idx_q == IdxLast) state_d = ST_MIX_A;
      ST_MIX_A: state_d = ST_MIX_B;
      ST_MIX_B: state_d = (step_q == StepLast) ? ST_IDLE : ST_MIX_A;
      ST_CIPH:  if (last_key) state_d = ST_HOLD;
      ST_HOLD:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath control: table port and ALU operands
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = a_q;
    ram_raddr    = idx_q;
    alu_req.mode = ALU_ADD;
    alu_req.x    = a_q;
    alu_req.y    = b_q;
    alu_req.k    = MagicQ;
    unique case (state_q)
      ST_IDLE: begin
        ram_raddr = (op == OpDecrypt) ? IdxLast : '0;
      end
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_raddr = '0;
      end
      ST_MIX_A: begin
        alu_req.mode = ALU_MIX_A;
        alu_req.k    = ram_rdata;
        ram_we       = 1'b1;
        ram_wdata    = alu_res;
      end
      ST_MIX_B: begin
        alu_req.mode = ALU_MIX_B;
        alu_req.k    = kw_q[w_q];
        ram_raddr    = idx_next_mix;
      end
      ST_CIPH: begin
        alu_req.x = odd ? b_q : a_q;
        alu_req.y = odd ? a_q : b_q;
        alu_req.k = ram_rdata;
        if (idx_q < IdxW'(2)) begin
          alu_req.mode = dec_q ? ALU_SUB : ALU_ADD;
        end else begin
          alu_req.mode = dec_q ? ALU_DEC : ALU_ENC;
        end
        ram_raddr = idx_next_ciph;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  rc5_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  rc5_ram #(
    .Depth (TableSize),
    .Width (WordW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          step_q <= '0;
          w_q    <= '0;
          dec_q  <= (op == OpDecrypt);
          idx_q  <= (op == OpDecrypt) ? IdxLast : '0;
          if (op == OpExpand) begin
            a_q      <= MagicP;
            b_q      <= '0;
            kw_q[0] <= key_low_q[31:0];
            kw_q[1] <= key_low_q[63:32];
            kw_q[2] <= key_high_q[31:0];
            kw_q[3] <= key_high_q[63:32];
          end else begin
            a_q <= s_axis_tdata[31:0];
            b_q <= s_axis_tdata[63:32];
          end
        end
      end
      ST_INIT: begin
        // accumulate the magic progression; clear for mixing at the end
        if (idx_q == IdxLast) begin
          a_q   <= '0;
          idx_q <= '0;
        end else begin
          a_q   <= alu_res;
          idx_q <= idx_q + IdxW'(1);
        end
      end
      ST_MIX_A: begin
        a_q <= alu_res;
      end
      ST_MIX_B: begin
        b_q       <= alu_res;
        kw_q[w_q] <= alu_res;
        w_q       <= w_q + 2'd1;
        idx_q     <= idx_next_mix;
        step_q    <= step_q + StepW'(1);
      end
      ST_CIPH: begin
        if (odd) begin
          b_q <= alu_res;
        end else begin
          a_q <= alu_res;
        end
        if (!last_key) begin
          idx_q <= idx_next_ciph;
        end
      end
      default: begin
        a_q <= a_q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_HOLD && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_HOLD && out_free) begin
      m_data_q <= {b_q, a_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

@@ hdl/rc5_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_chk
// Port-level checks of the RC5 block cipher, bound to the top level.
// ----------------------------------------------------------------------------
module rc5_chk (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic [63:0]               s_axis_tdata,
  input wire logic [1:0]                s_axis_tuser,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [63:0]               m_axis_tdata,
  input wire logic                      psel,
  input wire logic                      penable,
  input wire logic                      pwrite,
  input wire logic [rc5_pkg::AddrW-1:0] paddr,
  input wire logic [rc5_pkg::RegW-1:0]  pwdata,
  input wire logic [rc5_pkg::RegW-1:0]  prdata,
  input wire logic                      pready
);
  import rc5_pkg::*;

  logic s_fire;
  assign s_fire = s_axis_tvalid & s_axis_tready;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped or changed while stalled");

  // a cipher word keeps the block busy: s_axis_tready stays low after the accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == OpEncrypt || s_axis_tuser == OpDecrypt)
    |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input accepted while a block is in flight");

  // expand produces no output word
  a_expand_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tuser == OpExpand && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("output word after key expand");

  // a written key reads back
  a_key_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready ##1 !pwrite && paddr == $past(paddr)
    |-> prdata == $past(pwdata))
    else $error("key register read-back mismatch");

endmodule

bind rc5_block_cipher rc5_chk u_rc5_chk (.*);
`default_nettype wire

@@ bench/tb_rc5_block_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc5_block_cipher
// Self-checking bench for the RC5-32 cipher: keys go in over APB, then
// expand, encrypt and decrypt words stream in with random gaps on both sides.
// Every returned block is compared with a behavioral model of the cipher.
// ----------------------------------------------------------------------------
module tb_rc5_block_cipher;
  import rc5_pkg::*;

  localparam int RoundCnt = 12;
  localparam int TblN = 2 * (RoundCnt + 1);
  localparam int SettleCycles = 400;
  localparam int PhaseWords = 100;

  // op code with no operation behind it
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } cipher_word_t;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
  } block_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic s_axis_tvalid = 1'b0;
  wire logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // word_a [31:0], word_b [63:32]
  logic [1:0] s_axis_tuser = OpExpand;  // op [1:0]
  wire logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  wire logic [63:0] m_axis_tdata;  // out_a [31:0], out_b [63:32]
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [RegW-1:0] pwdata = '0;
  wire logic [RegW-1:0] prdata;
  wire logic pready;

  // model state
  logic [63:0] key_lo_q = '0;
  logic [63:0] key_hi_q = '0;
  logic [31:0] sched_tbl[TblN];
  logic [31:0] key_scratch[KeyWords];

  cipher_word_t pending_words[$];
  block_t expected_blocks[$];
  cipher_word_t cur_word;
  bit word_live = 1'b0;
  bit in_taken = 1'b0;
  bit no_gaps = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned fail_cnt = 0;

  rc5_block_cipher #(
    .NUM_ROUNDS(RoundCnt)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] s);
    if (s == 5'd0) begin
      return x;
    end
    return (x << s) | (x >> (6'd32 - s));
  endfunction

  function automatic void schedule_expand();
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] amt;
    int ti;
    int wi;
    ma = '0;
    mb = '0;
    ti = 0;
    wi = 0;
    key_scratch[0] = key_lo_q[31:0];
    key_scratch[1] = key_lo_q[63:32];
    key_scratch[2] = key_hi_q[31:0];
    key_scratch[3] = key_hi_q[63:32];
    sched_tbl[0] = MagicP;
    for (int n = 1; n < TblN; n++) begin
      sched_tbl[n] = sched_tbl[n-1] + MagicQ;
    end
    for (int n = 0; n < 3 * TblN; n++) begin
      ma = rol32(sched_tbl[ti] + ma + mb, MixRot);
      sched_tbl[ti] = ma;
      amt = ma + mb;
      mb = rol32(key_scratch[wi] + ma + mb, amt[4:0]);
      key_scratch[wi] = mb;
      ti = (ti + 1) % TblN;
      wi = (wi + 1) % KeyWords;
    end
  endfunction

  // apply one accepted word to the model; queue a block where one comes back
  function automatic void cipher_accept(input cipher_word_t w);
    logic [31:0] ra;
    logic [31:0] rb;
    ra = w.a;
    rb = w.b;
    case (w.op)
      OpExpand: begin
        schedule_expand();
      end
      OpEncrypt: begin
        ra = ra + sched_tbl[0];
        rb = rb + sched_tbl[1];
        for (int r = 1; r <= RoundCnt; r++) begin
          ra = rol32(ra ^ rb, rb[4:0]) + sched_tbl[2*r];
          rb = rol32(rb ^ ra, ra[4:0]) + sched_tbl[2*r+1];
        end
        expected_blocks.push_back('{a: ra, b: rb});
      end
      OpDecrypt: begin
        // right rotation by s is left rotation by -s mod 32
        for (int r = RoundCnt; r >= 1; r--) begin
          rb = rol32(rb - sched_tbl[2*r+1], 5'd0 - ra[4:0]) ^ ra;
          ra = rol32(ra - sched_tbl[2*r], 5'd0 - rb[4:0]) ^ rb;
        end
        ra = ra - sched_tbl[0];
        rb = rb - sched_tbl[1];
        expected_blocks.push_back('{a: ra, b: rb});
      end
      default: begin
        // unused op: dropped by the block
      end
    endcase
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned pick;
    if (no_gaps) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end
    if (pick < 94) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 50);
  endfunction

  function automatic logic [31:0] draw_data();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return '0;
    end
    if (pick == 1) begin
      return '1;
    end
    return $urandom;
  endfunction

  function automatic void add_word(input logic [1:0] op, input logic [31:0] a,
                                   input logic [31:0] b);
    pending_words.push_back('{op: op, a: a, b: b});
  endfunction

  // input side: advance to the next word once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_taken = 1'b0;
        word_live = 1'b0;
        in_gap = draw_gap();
      end
      if (!word_live) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          word_live = 1'b1;
        end
      end
      s_axis_tvalid <= word_live;
      if (word_live) begin
        s_axis_tdata <= {cur_word.b, cur_word.a};
        s_axis_tuser <= cur_word.op;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      in_taken = 1'b1;
      cipher_accept(cur_word);
    end
  end

  // output side: random stalls on tready
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        out_stall = draw_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    block_t exp_blk;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected block %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (m_axis_tdata[31:0] !== exp_blk.a) begin
          $error("out_a: expected %h, got %h", exp_blk.a, m_axis_tdata[31:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[63:32] !== exp_blk.b) begin
          $error("out_b: expected %h, got %h", exp_blk.b, m_axis_tdata[63:32]);
          fail_cnt++;
        end
      end
    end
  end

  task automatic write_key(input logic idx, input logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegKeyHigh) begin
      key_hi_q = val;
    end else begin
      key_lo_q = val;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // hold until every word is taken, every block is back and an expand is done
  task automatic drain_all();
    while (pending_words.size() != 0 || word_live || expected_blocks.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero key, extreme blocks, zero rotation on decrypt, unused op
    write_key(RegKeyLow, '0);
    write_key(RegKeyHigh, '0);
    add_word(OpExpand, 32'h0, 32'h0);
    add_word(OpEncrypt, 32'h0, 32'h0);
    add_word(OpEncrypt, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(OpDecrypt, 32'h0, 32'h0);
    add_word(OpDecrypt, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(OpEncrypt, 32'h0, 32'hFFFF_FFFF);
    add_word(OpDecrypt, 32'hFFFF_FFE0, 32'h1234_5678);
    add_word(OpUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(OpEncrypt, 32'h5555_5555, 32'hAAAA_AAAA);
    drain_all();

    // new key without expand keeps the old schedule
    write_key(RegKeyLow, '1);
    write_key(RegKeyHigh, '1);
    add_word(OpEncrypt, 32'h0, 32'h0);
    add_word(OpDecrypt, 32'hFFFF_FFFF, 32'h0);
    add_word(OpExpand, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(OpEncrypt, 32'h0, 32'h0);
    add_word(OpDecrypt, 32'h0, 32'hFFFF_FFFF);
    add_word(OpEncrypt, 32'h8000_0000, 32'h0000_0001);
    drain_all();

    write_key(RegKeyLow, 64'h0706_0504_0302_0100);
    write_key(RegKeyHigh, 64'h0F0E_0D0C_0B0A_0908);
    add_word(OpExpand, 32'h0, 32'h0);
    add_word(OpEncrypt, 32'h0011_2233, 32'h4455_6677);
    add_word(OpDecrypt, 32'h0011_2233, 32'h4455_6677);
    add_word(OpEncrypt, 32'h0000_001F, 32'h0000_0000);
    drain_all();

    // random phases, each with its own key setting
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_key(RegKeyLow, '1);
          write_key(RegKeyHigh, '1);
        end
        2: begin
          write_key(RegKeyLow, {$urandom, $urandom});
          write_key(RegKeyHigh, '0);
        end
        default: begin
          write_key(RegKeyLow, {$urandom, $urandom});
          write_key(RegKeyHigh, {$urandom, $urandom});
        end
      endcase
      no_gaps = (p == 2);
      // phase 3 runs on the previous schedule until a random expand comes
      if (p != 3) begin
        add_word(OpExpand, $urandom, $urandom);
      end
      for (int i = 0; i < PhaseWords; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          add_word(OpExpand, $urandom, $urandom);
        end else if (pick < 52) begin
          add_word(OpEncrypt, draw_data(), draw_data());
        end else begin
          add_word(OpDecrypt, draw_data(), draw_data());
        end
        if ($urandom_range(0, 99) < 3) begin
          add_word(OpUnused, $urandom, $urandom);
        end
      end
      drain_all();
    end

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
